[rtl/tar_pkg.sv]
// ----------------------------------------------------------------------------
// tar_pkg
// Types, field widths and codes shared by the tile animation remapper files.
// ----------------------------------------------------------------------------
`default_nettype none

package tar_pkg;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 7;
  localparam int TILE_W   = 10;
  localparam int DELAY_W  = 16;
  localparam int MODE_W   = 2;
  localparam int FIRED_W  = 7;
  localparam int RAND_W   = 32;
  localparam int DIV_W    = TILE_W + 1;
  localparam int BITCNT_W = $clog2(RAND_W);

  localparam logic [RAND_W-1:0]  LFSR_TAPS = 32'hD000_0001;
  localparam logic [RAND_W-1:0]  RAND_RESET = 32'h0000_0001;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 16'hFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_ANIM_WR  = 2'd1,
    ACT_REMAP_WR = 2'd2,
    ACT_REMAP_RD = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FWD  = 2'd0,
    MODE_BWD  = 2'd1,
    MODE_RAND = 2'd2,
    MODE_PONG = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SLOT_RD,
    ST_SLOT_EVAL,
    ST_SLOT_NEXT,
    ST_TILE_CHK,
    ST_TILE_CALC,
    ST_TILE_MOD,
    ST_TILE_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TILE_W-1:0]  start;
    logic [TILE_W-1:0]  finish;
    logic [DELAY_W-1:0] delay;
    mode_t              mode;
  } anim_entry_t;

  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [TILE_W-1:0] remainder;
  } mod_rsp_t;

endpackage

`default_nettype wire

[rtl/tar_in_if.sv]
// ----------------------------------------------------------------------------
// tar_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tar_in_if;
  logic                          valid;
  logic                          ready;
  logic [tar_pkg::ACTION_W-1:0]  action;
  logic [tar_pkg::SLOT_W-1:0]    anim_slot;
  logic [tar_pkg::TILE_W-1:0]    range_start;
  logic [tar_pkg::TILE_W-1:0]    range_finish;
  logic [tar_pkg::DELAY_W-1:0]   frame_delay;
  logic [tar_pkg::MODE_W-1:0]    anim_mode;
  logic [tar_pkg::TILE_W-1:0]    tile_number;
  logic [tar_pkg::TILE_W-1:0]    tile_value;

  modport source (
    output valid, action, anim_slot, range_start, range_finish, frame_delay,
           anim_mode, tile_number, tile_value,
    input  ready
  );
  modport sink (
    input  valid, action, anim_slot, range_start, range_finish, frame_delay,
           anim_mode, tile_number, tile_value,
    output ready
  );
endinterface

`default_nettype wire

[rtl/tar_out_if.sv]
// ----------------------------------------------------------------------------
// tar_out_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tar_out_if;
  logic                          valid;
  logic                          ready;
  logic [tar_pkg::TILE_W-1:0]    read_value;
  logic [tar_pkg::FIRED_W-1:0]   fired_count;

  modport source (output valid, read_value, fired_count, input ready);
  modport sink   (input valid, read_value, fired_count, output ready);
endinterface

`default_nettype wire

[rtl/tar_cfg_if.sv]
// ----------------------------------------------------------------------------
// tar_cfg_if
// Configuration write channel carrying the random seed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tar_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tar_pkg::RAND_W-1:0]   random_seed;

  modport source (output valid, random_seed, input ready);
  modport sink   (input valid, random_seed, output ready);
endinterface

`default_nettype wire

[rtl/tile_animation_remapper_core.sv]
// ----------------------------------------------------------------------------
// tile_animation_remapper_core
// Tile remap table with timed animation entries stepped on each tick word.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  in_chan   | in  | valid/ready   | action, slot, range, delay, mode, tile
//  out_chan  | out | valid/ready   | read_value, fired_count
//  cfg_chan  | in  | valid/ready   | random_seed (also loads the generator)
//
//  A tick reads and evaluates every animation entry and steps the tiles of each
//  firing entry whose start is not past its finish; a tile beyond the table is
//  skipped, and a random-mode tile waits for the bit-serial remainder unit.
//  After reset a clearing pass zeroes the tables; no input word is taken
//  meanwhile. Input is taken only when idle; a result still waiting on
//  out_chan holds the sequencer in its done state.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_animation_remapper_core #(
  parameter int NUM_TILES = 1024,
  parameter int NUM_ANIMS = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  tar_in_if.sink     in_chan,
  tar_out_if.source  out_chan,
  tar_cfg_if.sink    cfg_chan
);

  localparam int TILE_W  = tar_pkg::TILE_W;
  localparam int TW      = $clog2(NUM_TILES);
  localparam int AW      = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int CLR_LEN = (NUM_TILES > NUM_ANIMS) ? NUM_TILES : NUM_ANIMS;
  localparam int CW      = $clog2(CLR_LEN);
  localparam int CMPW    = CW + 1;
  localparam int TCW     = ((TW + 1) > TILE_W) ? TW + 1 : TILE_W + 1;
  localparam int SCW     = ((AW + 1) > tar_pkg::SLOT_W) ? AW + 1 : tar_pkg::SLOT_W + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_ANIMS - 1);

  // Storage
  logic [TILE_W-1:0]             remap_mem [NUM_TILES];
  logic                          pong_mem  [NUM_TILES];
  tar_pkg::anim_entry_t          anim_mem  [NUM_ANIMS];
  logic [tar_pkg::DELAY_W-1:0]   cnt_mem   [NUM_ANIMS];

  logic [TILE_W-1:0]             remap_q;
  logic                          pong_q;
  tar_pkg::anim_entry_t          anim_q;
  logic [tar_pkg::DELAY_W-1:0]   cnt_q;

  // Memory port controls
  logic                          remap_we, pong_we, remap_re;
  logic [TW-1:0]                 remap_waddr, remap_raddr;
  logic [TILE_W-1:0]             remap_wdata;
  logic                          pong_wdata;
  logic                          anim_we, anim_re;
  logic [AW-1:0]                 anim_waddr;
  tar_pkg::anim_entry_t          anim_wdata;
  logic                          cnt_we;
  logic [tar_pkg::DELAY_W-1:0]   cnt_wdata;

  // Sequencer state
  tar_pkg::state_t               state_r, state_nxt;
  logic [CW-1:0]                 clr_r, clr_nxt;
  logic [AW-1:0]                 slot_r, slot_nxt;
  logic [TILE_W-1:0]             tile_r, tile_nxt;
  logic [tar_pkg::FIRED_W-1:0]   fired_r, fired_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic [tar_pkg::RAND_W-1:0]    rand_r, rand_nxt;
  logic [TILE_W-1:0]             res_rv_r, res_rv_nxt;
  logic [tar_pkg::FIRED_W-1:0]   res_fc_r, res_fc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [TILE_W-1:0]             out_rv_r, out_rv_nxt;
  logic [tar_pkg::FIRED_W-1:0]   out_fc_r, out_fc_nxt;

  tar_pkg::mod_req_t             mod_req;
  tar_pkg::mod_rsp_t             mod_rsp;

  logic                          accept, tnum_ok, slot_ok, tile_ok, fire;
  logic                          clr_tile, clr_anim;
  logic [tar_pkg::RAND_W-1:0]    rand_step;
  logic [TILE_W-1:0]             step_v;
  logic                          step_f;
  tar_pkg::action_t              act;

  tar_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_chan.ready        = (state_r == tar_pkg::ST_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_value  = out_rv_r;
  assign out_chan.fired_count = out_fc_r;

  assign accept   = in_chan.valid && in_chan.ready;
  assign act      = tar_pkg::action_t'(in_chan.action);
  assign tnum_ok  = TCW'(in_chan.tile_number) < TCW'(NUM_TILES);
  assign slot_ok  = SCW'(in_chan.anim_slot) < SCW'(NUM_ANIMS);
  assign tile_ok  = TCW'(tile_r) < TCW'(NUM_TILES);
  assign clr_tile = CMPW'(clr_r) < CMPW'(NUM_TILES);
  assign clr_anim = CMPW'(clr_r) < CMPW'(NUM_ANIMS);
  assign fire     = (anim_q.delay != '0) && (anim_q.delay < cnt_q);

  // Galois LFSR advance, one step per random-mode tile.
  assign rand_step = {1'b0, rand_r[tar_pkg::RAND_W-1:1]}
                   ^ (rand_r[0] ? tar_pkg::LFSR_TAPS : '0);

  assign mod_req.dividend = rand_step;
  assign mod_req.divisor  = {1'b0, anim_q.finish} - {1'b0, anim_q.start}
                          + tar_pkg::DIV_W'(1);
  assign mod_req.start    = (state_r == tar_pkg::ST_TILE_CALC)
                          && (anim_q.mode == tar_pkg::MODE_RAND);

  // Next tile value for the non-random modes; tile arithmetic wraps.
  always_comb begin
    step_v = remap_q;
    step_f = pong_q;
    case (anim_q.mode)
      tar_pkg::MODE_FWD: begin
        step_v = (remap_q < anim_q.finish) ? remap_q + 1'b1 : anim_q.start;
      end
      tar_pkg::MODE_BWD: begin
        step_v = (remap_q > anim_q.start) ? remap_q - 1'b1 : anim_q.finish;
      end
      tar_pkg::MODE_PONG: begin
        if (pong_q) begin
          if (remap_q != anim_q.start) begin
            step_v = remap_q - 1'b1;
          end else begin
            step_v = remap_q + 1'b1;
            step_f = 1'b0;
          end
        end else begin
          if (remap_q != anim_q.finish) begin
            step_v = remap_q + 1'b1;
          end else begin
            step_v = remap_q - 1'b1;
            step_f = 1'b1;
          end
        end
      end
      default: begin
        step_v = remap_q;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    tile_nxt      = tile_r;
    fired_nxt     = fired_r;
    rd_ok_nxt     = rd_ok_r;
    rand_nxt      = rand_r;
    res_rv_nxt    = res_rv_r;
    res_fc_nxt    = res_fc_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_rv_nxt    = out_rv_r;
    out_fc_nxt    = out_fc_r;

    remap_we    = 1'b0;
    pong_we     = 1'b0;
    remap_re    = 1'b0;
    remap_waddr = TW'(tile_r);
    remap_raddr = TW'(tile_r);
    remap_wdata = step_v;
    pong_wdata  = step_f;
    anim_we     = 1'b0;
    anim_re     = 1'b0;
    anim_waddr  = AW'(in_chan.anim_slot);
    anim_wdata.start  = in_chan.range_start;
    anim_wdata.finish = in_chan.range_finish;
    anim_wdata.delay  = in_chan.frame_delay;
    anim_wdata.mode   = tar_pkg::mode_t'(in_chan.anim_mode);
    cnt_we      = 1'b0;
    cnt_wdata   = (cnt_q == tar_pkg::DELAY_MAX) ? cnt_q : cnt_q + 1'b1;

    unique case (state_r)
      tar_pkg::ST_CLEAR: begin
        remap_we    = clr_tile;
        pong_we     = clr_tile;
        remap_waddr = clr_r[TW-1:0];
        remap_wdata = '0;
        pong_wdata  = 1'b0;
        anim_we     = clr_anim;
        anim_waddr  = clr_r[AW-1:0];
        anim_wdata  = '0;
        cnt_we      = clr_anim;
        cnt_wdata   = '0;
        if (clr_r == CW'(CLR_LEN - 1)) begin
          state_nxt = tar_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      tar_pkg::ST_IDLE: begin
        if (accept) begin
          res_rv_nxt = '0;
          res_fc_nxt = '0;
          unique case (act)
            tar_pkg::ACT_TICK: begin
              fired_nxt = '0;
              slot_nxt  = '0;
              state_nxt = tar_pkg::ST_SLOT_RD;
            end
            tar_pkg::ACT_ANIM_WR: begin
              anim_we   = slot_ok;
              state_nxt = tar_pkg::ST_DONE;
            end
            tar_pkg::ACT_REMAP_WR: begin
              remap_we    = tnum_ok;
              remap_waddr = TW'(in_chan.tile_number);
              remap_wdata = in_chan.tile_value;
              state_nxt   = tar_pkg::ST_DONE;
            end
            tar_pkg::ACT_REMAP_RD: begin
              remap_re    = 1'b1;
              remap_raddr = TW'(in_chan.tile_number);
              rd_ok_nxt   = tnum_ok;
              state_nxt   = tar_pkg::ST_READ;
            end
            default: begin
              state_nxt = tar_pkg::ST_DONE;
            end
          endcase
        end
      end
      tar_pkg::ST_READ: begin
        res_rv_nxt = rd_ok_r ? remap_q : '0;
        state_nxt  = tar_pkg::ST_DONE;
      end
      tar_pkg::ST_SLOT_RD: begin
        anim_re   = 1'b1;
        state_nxt = tar_pkg::ST_SLOT_EVAL;
      end
      tar_pkg::ST_SLOT_EVAL: begin
        // A firing entry restarts at zero and then counts this tick.
        cnt_we = 1'b1;
        if (fire) begin
          cnt_wdata = tar_pkg::DELAY_W'(1);
          fired_nxt = fired_r + 1'b1;
        end
        if (fire && (anim_q.start <= anim_q.finish)) begin
          tile_nxt  = anim_q.start;
          state_nxt = tar_pkg::ST_TILE_CHK;
        end else begin
          state_nxt = tar_pkg::ST_SLOT_NEXT;
        end
      end
      tar_pkg::ST_SLOT_NEXT: begin
        if (slot_r == LAST_SLOT) begin
          res_rv_nxt = '0;
          res_fc_nxt = fired_r;
          state_nxt  = tar_pkg::ST_DONE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = tar_pkg::ST_SLOT_RD;
        end
      end
      tar_pkg::ST_TILE_CHK: begin
        if (tile_ok) begin
          remap_re  = 1'b1;
          state_nxt = tar_pkg::ST_TILE_CALC;
        end else begin
          state_nxt = tar_pkg::ST_TILE_NEXT;
        end
      end
      tar_pkg::ST_TILE_CALC: begin
        if (anim_q.mode == tar_pkg::MODE_RAND) begin
          rand_nxt  = rand_step;
          state_nxt = tar_pkg::ST_TILE_MOD;
        end else begin
          remap_we  = 1'b1;
          pong_we   = (anim_q.mode == tar_pkg::MODE_PONG);
          state_nxt = tar_pkg::ST_TILE_NEXT;
        end
      end
      tar_pkg::ST_TILE_MOD: begin
        if (mod_rsp.done) begin
          remap_we    = 1'b1;
          remap_wdata = anim_q.start + mod_rsp.remainder;
          state_nxt   = tar_pkg::ST_TILE_NEXT;
        end
      end
      tar_pkg::ST_TILE_NEXT: begin
        if (tile_r == anim_q.finish) begin
          state_nxt = tar_pkg::ST_SLOT_NEXT;
        end else begin
          tile_nxt  = tile_r + 1'b1;
          state_nxt = tar_pkg::ST_TILE_CHK;
        end
      end
      tar_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = res_rv_r;
          out_fc_nxt    = res_fc_r;
          state_nxt     = tar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tar_pkg::ST_IDLE;
      end
    endcase

    // A seed write reloads the generator.
    if (cfg_chan.valid && cfg_chan.ready) begin
      rand_nxt = cfg_chan.random_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tar_pkg::ST_CLEAR;
      clr_r       <= '0;
      slot_r      <= '0;
      tile_r      <= '0;
      fired_r     <= '0;
      rd_ok_r     <= 1'b0;
      rand_r      <= tar_pkg::RAND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      slot_r      <= slot_nxt;
      tile_r      <= tile_nxt;
      fired_r     <= fired_nxt;
      rd_ok_r     <= rd_ok_nxt;
      rand_r      <= rand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_rv_r <= res_rv_nxt;
    res_fc_r <= res_fc_nxt;
    out_rv_r <= out_rv_nxt;
    out_fc_r <= out_fc_nxt;
  end

  always_ff @(posedge clk) begin
    if (remap_we) begin
      remap_mem[remap_waddr] <= remap_wdata;
    end
    if (pong_we) begin
      pong_mem[remap_waddr] <= pong_wdata;
    end
    if (remap_re) begin
      remap_q <= remap_mem[remap_raddr];
      pong_q  <= pong_mem[remap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (anim_we) begin
      anim_mem[anim_waddr] <= anim_wdata;
    end
    if (cnt_we) begin
      cnt_mem[(state_r == tar_pkg::ST_CLEAR) ? clr_r[AW-1:0] : slot_r] <= cnt_wdata;
    end
    if (anim_re) begin
      anim_q <= anim_mem[slot_r];
      cnt_q  <= cnt_mem[slot_r];
    end
  end

endmodule

`default_nettype wire

[rtl/tar_mod_unit.sv]
// ----------------------------------------------------------------------------
// tar_mod_unit
// Bit-serial restoring remainder unit: 32-bit dividend by an 11-bit divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tar_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tar_pkg::mod_req_t req,
  output tar_pkg::mod_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [tar_pkg::BITCNT_W-1:0]   bit_r, bit_nxt;
  logic [tar_pkg::RAND_W-1:0]     num_r, num_nxt;
  logic [tar_pkg::DIV_W-1:0]      den_r, den_nxt;
  logic [tar_pkg::TILE_W-1:0]     rem_r, rem_nxt;
  logic [tar_pkg::DIV_W-1:0]      trial;

  // The partial remainder stays below the divisor, which is at most 1024,
  // so it always fits the tile width.
  assign trial = {rem_r, num_r[tar_pkg::RAND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      bit_nxt  = '0;
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= den_r) begin
        rem_nxt = tar_pkg::TILE_W'(trial - den_r);
      end else begin
        rem_nxt = trial[tar_pkg::TILE_W-1:0];
      end
      num_nxt = {num_r[tar_pkg::RAND_W-2:0], 1'b0};
      bit_nxt = bit_r + 1'b1;
      if (bit_r == tar_pkg::BITCNT_W'(tar_pkg::RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire
